// ----- hdl/button_debounce_autorepeat_unit_assert.svh -----
// Assertion macros shared by the button debounce RTL files.
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_UNIT_ASSERT_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_UNIT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked only out of reset.
`define BDA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked only out of reset.
`define BDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BDA_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define BDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- hdl/bda_pkg.sv -----
// Types and constants of the button debounce and auto-repeat unit.
package bda_pkg;

    localparam int unsigned PIN_W   = 4;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned TIMER_W = 8;
    localparam int unsigned PEND_W  = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 8;

    localparam logic [TIMER_W-1:0] LONG_DELAY_RST      = 8'd100;
    localparam logic [TIMER_W-1:0] REPEAT_INTERVAL_RST = 8'd20;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK   = 2'd0,
        MODE_READ   = 2'd1,
        MODE_TOGGLE = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESSED_LEVEL   = 2'd0,
        CFG_LONG_DELAY      = 2'd1,
        CFG_REPEAT_INTERVAL = 2'd2
    } t_cfg_index;

    // Control shared by all button lanes for the beat being processed.
    typedef struct packed {
        logic                advance;
        logic [MODE_W-1:0]   mode;
        logic                pressed_level;
        logic [TIMER_W-1:0]  long_delay;
        logic [TIMER_W-1:0]  repeat_interval;
    } t_lane_ctrl;

endpackage

// ----- hdl/button_debounce_autorepeat_unit.sv -----
// Top level of the button debounce and auto-repeat unit.
// Each accepted beat is held in the input register; the button lanes then update their state
// on the edge that moves it on, as the output register captures the result. The output register
// lets a new beat be accepted while a result waits, so the sustained rate is one beat per clock
// whenever the output side is ready.
// A tick (tuser 0) shifts every button's pin sample into its three-deep history, a read (tuser 1)
// returns and clears one button's event flag, a toggle (tuser 2) forces a press and release of
// one button. Configuration writes are taken at once and should only be issued when idle.
module button_debounce_autorepeat_unit #(
    parameter int unsigned BUTTONS = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // Configuration write port.
    input  logic                             i_cfg_wr_en,
    input  logic [bda_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bda_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Input stream.
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [bda_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,  // pin_levels[3:0], button_index[5:4]
    input  logic [bda_pkg::MODE_W-1:0]       i_s_axis_tuser,  // mode[1:0]
    // Result stream.
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [bda_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata   // pressed_event[0], pending_flags[4:1]
);
    import bda_pkg::*;

    `include "button_debounce_autorepeat_unit_assert.svh"

    // Configuration registers.
    logic               r_pressed_level;
    logic [TIMER_W-1:0] r_long_delay;
    logic [TIMER_W-1:0] r_repeat_interval;

    // Input register.
    logic               r_in_valid;
    logic [MODE_W-1:0]  r_mode;
    logic [PIN_W-1:0]   r_pins;
    logic [IDX_W-1:0]   r_index;

    // Output register.
    logic               r_out_valid;
    logic               r_out_event;

    logic               w_advance;
    logic               w_s_fire;
    t_lane_ctrl         w_ctrl;
    logic [BUTTONS-1:0] w_flags;
    logic [BUTTONS-1:0] w_sel;
    logic [BUTTONS-1:0] w_level;
    logic               n_out_event;
    logic [PEND_W-1:0]  w_pend;

    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_s_fire        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed_level   <= 1'b0;
            r_long_delay      <= LONG_DELAY_RST;
            r_repeat_interval <= REPEAT_INTERVAL_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_PRESSED_LEVEL:   r_pressed_level   <= i_cfg_data[0];
                CFG_LONG_DELAY:      r_long_delay      <= i_cfg_data[TIMER_W-1:0];
                CFG_REPEAT_INTERVAL: r_repeat_interval <= i_cfg_data[TIMER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_fire) begin
            r_mode  <= i_s_axis_tuser;
            r_pins  <= i_s_axis_tdata[PIN_W-1:0];
            r_index <= i_s_axis_tdata[PIN_W +: IDX_W];
        end
    end

    assign w_ctrl = '{
        advance:         w_advance,
        mode:            r_mode,
        pressed_level:   r_pressed_level,
        long_delay:      r_long_delay,
        repeat_interval: r_repeat_interval
    };

    for (genvar b = 0; b < BUTTONS; b++) begin : g_button
        // Only the first four buttons have a pin and an index; the rest sample level 0.
        if (b < PIN_W) begin : g_pin
            assign w_level[b] = r_pins[b];
            assign w_sel[b]   = (r_index == IDX_W'(b));
        end else begin : g_nopin
            assign w_level[b] = 1'b0;
            assign w_sel[b]   = 1'b0;
        end

        bda_button u_button (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_level (w_level[b]),
            .i_sel   (w_sel[b]),
            .o_flag  (w_flags[b])
        );
    end

    always_comb begin
        n_out_event = 1'b0;
        if (r_mode == MODE_READ) begin
            for (int unsigned b = 0; b < BUTTONS; b++) begin
                if (w_sel[b] && w_flags[b]) begin
                    n_out_event = 1'b1;
                end
            end
        end
    end

    for (genvar p = 0; p < PEND_W; p++) begin : g_pend
        if (p < BUTTONS) begin : g_have
            assign w_pend[p] = w_flags[p];
        end else begin : g_none
            assign w_pend[p] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_event <= n_out_event;
        end
    end

    // The lanes change only on the edge that moves a beat to the output, so their flags are
    // exactly the pending flags of the beat that is on the output.
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'({w_pend, r_out_event});

    `BDA_ASSERT_NEXT(a_event_only_on_read, i_clk, i_rst_n,
        w_advance && r_mode != MODE_READ, !r_out_event)
    `BDA_ASSERT_NEXT(a_read_hit_reports, i_clk, i_rst_n,
        w_advance && r_mode == MODE_READ && (w_sel & w_flags) != '0, r_out_event)
    `BDA_ASSERT_NEXT(a_out_held, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))
endmodule

// ----- hdl/bda_button.sv -----
// Per-button sample history, stable level, hold timer and event flag.
module bda_button (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bda_pkg::t_lane_ctrl i_ctrl,
    input  logic              i_level,
    input  logic              i_sel,
    output logic              o_flag
);
    import bda_pkg::*;

    `include "button_debounce_autorepeat_unit_assert.svh"

    logic               r_new, r_mid, r_old, r_stable, r_flag;
    logic [TIMER_W-1:0] r_timer;
    logic               n_new, n_mid, n_old, n_stable, n_flag;
    logic [TIMER_W-1:0] n_timer;
    logic               w_agree;
    logic               w_pl;

    assign w_pl    = i_ctrl.pressed_level;
    // After the shift, newest is i_level, middle is r_new, oldest is r_mid.
    assign w_agree = (i_level == r_new) && (r_new == r_mid);

    always_comb begin
        n_new    = r_new;
        n_mid    = r_mid;
        n_old    = r_old;
        n_stable = r_stable;
        n_flag   = r_flag;
        n_timer  = r_timer;
        if (i_ctrl.advance) begin
            unique case (i_ctrl.mode)
                MODE_TICK: begin
                    n_new = i_level;
                    n_mid = r_new;
                    n_old = r_mid;
                    if (w_agree) begin
                        if (r_stable != r_mid) begin
                            n_stable = r_mid;
                            if (r_mid == w_pl) begin
                                n_flag  = 1'b1;
                                n_timer = i_ctrl.long_delay;
                            end
                        end else if (r_stable == w_pl) begin
                            if (r_timer != '0) begin
                                n_timer = r_timer - TIMER_W'(1);
                            end else begin
                                n_flag  = 1'b1;
                                n_timer = i_ctrl.repeat_interval;
                            end
                        end
                    end
                end
                MODE_READ: begin
                    if (i_sel) begin
                        n_flag = 1'b0;
                    end
                end
                MODE_TOGGLE: begin
                    if (i_sel) begin
                        // Forced press, then forced release.
                        if (r_stable != w_pl) begin
                            n_flag  = 1'b1;
                            n_timer = i_ctrl.long_delay;
                        end
                        n_new    = ~w_pl;
                        n_mid    = ~w_pl;
                        n_old    = ~w_pl;
                        n_stable = ~w_pl;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_new    <= 1'b0;
            r_mid    <= 1'b0;
            r_old    <= 1'b0;
            r_stable <= 1'b0;
            r_flag   <= 1'b0;
            r_timer  <= '0;
        end else begin
            r_new    <= n_new;
            r_mid    <= n_mid;
            r_old    <= n_old;
            r_stable <= n_stable;
            r_flag   <= n_flag;
            r_timer  <= n_timer;
        end
    end

    assign o_flag = r_flag;

    `BDA_ASSERT_NEXT(a_toggle_releases, i_clk, i_rst_n,
        i_ctrl.advance && i_ctrl.mode == MODE_TOGGLE && i_sel,
        r_stable == !$past(w_pl) && r_old == !$past(w_pl))
    `BDA_ASSERT_NEXT(a_read_clears, i_clk, i_rst_n,
        i_ctrl.advance && i_ctrl.mode == MODE_READ && i_sel, !r_flag)
    `BDA_ASSERT_NOW(a_flag_source, i_clk, i_rst_n,
        $rose(r_flag),
        $past(i_ctrl.advance) &&
        ($past(i_ctrl.mode) == MODE_TICK || $past(i_ctrl.mode) == MODE_TOGGLE))
endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the four-button debounce and auto-repeat unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bda_pkg::*;

    localparam int unsigned NUM_BUTTONS = 4;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 100000;

    typedef struct packed {
        logic              pressed_event;
        logic [PEND_W-1:0] pending_flags;
    } t_button_report;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE,
        RX_HICCUP
    } t_rx_style;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic [MODE_W-1:0]     i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    // Model of the block: debounce history, stable levels, hold timers and flags.
    logic [NUM_BUTTONS-1:0] hist_new;
    logic [NUM_BUTTONS-1:0] hist_mid;
    logic [NUM_BUTTONS-1:0] hist_old;
    logic [NUM_BUTTONS-1:0] stable_lv;
    logic [NUM_BUTTONS-1:0] ev_flag;
    logic [TIMER_W-1:0]     hold_cnt [NUM_BUTTONS];
    logic                   press_lv;
    logic [TIMER_W-1:0]     long_dly;
    logic [TIMER_W-1:0]     rep_int;

    t_button_report expected_reports[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;

    t_rx_style   rx_style = RX_OPEN;
    int unsigned rx_left = 0;
    int unsigned rx_phase = 0;

    button_debounce_autorepeat_unit #(
        .BUTTONS(NUM_BUTTONS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),  // pin_levels[3:0], button_index[5:4]
        .i_s_axis_tuser  (i_s_axis_tuser),  // mode[1:0]
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)   // pressed_event[0], pending_flags[4:1]
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("button_debounce_autorepeat_unit: mismatch");
            $finish;
        end
    end

    function automatic t_button_report predict_debounce(input logic [MODE_W-1:0] mode,
                                                        input logic [PIN_W-1:0] pins,
                                                        input logic [IDX_W-1:0] idx);
        t_button_report rpt;
        rpt.pressed_event = 1'b0;
        if (mode == MODE_TICK) begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                hist_old[b] = hist_mid[b];
                hist_mid[b] = hist_new[b];
                hist_new[b] = pins[b];
                if (hist_new[b] == hist_mid[b] && hist_mid[b] == hist_old[b]) begin
                    if (stable_lv[b] != hist_old[b]) begin
                        stable_lv[b] = hist_old[b];
                        if (stable_lv[b] == press_lv) begin
                            ev_flag[b] = 1'b1;
                            hold_cnt[b] = long_dly;
                        end
                    end else if (stable_lv[b] == press_lv) begin
                        if (hold_cnt[b] != '0) begin
                            hold_cnt[b] = hold_cnt[b] - 1'b1;
                        end else begin
                            ev_flag[b] = 1'b1;
                            hold_cnt[b] = rep_int;
                        end
                    end
                end
            end
        end else if (mode == MODE_READ) begin
            rpt.pressed_event = ev_flag[idx];
            ev_flag[idx] = 1'b0;
        end else if (mode == MODE_TOGGLE) begin
            // Forced press first (event only if not already pressed), then forced release.
            if (stable_lv[idx] != press_lv) begin
                ev_flag[idx] = 1'b1;
                hold_cnt[idx] = long_dly;
            end
            hist_new[idx] = ~press_lv;
            hist_mid[idx] = ~press_lv;
            hist_old[idx] = ~press_lv;
            stable_lv[idx] = ~press_lv;
        end
        rpt.pending_flags = ev_flag;
        return rpt;
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        $display("%0t: %s", $time, msg);
    endtask

    // Result side: the stall pattern is picked anew at random times.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_style = t_rx_style'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 150);
        end
        rx_left--;
        rx_phase++;
        case (rx_style)
            RX_OPEN:   i_m_axis_tready <= 1'b1;
            RX_RANDOM: i_m_axis_tready <= $urandom_range(0, 1);
            RX_SPARSE: i_m_axis_tready <= (rx_phase % 4 == 0);
            default:   i_m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_button_report got;
        t_button_report want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.pressed_event = o_m_axis_tdata[0];
            got.pending_flags = o_m_axis_tdata[4:1];
            if (expected_reports.size() == 0) begin
                note_error($sformatf("unexpected beat: expected none, actual event %0b flags %b",
                                     got.pressed_event, got.pending_flags));
            end else begin
                want = expected_reports.pop_front();
                if (got.pressed_event !== want.pressed_event) begin
                    note_error($sformatf("pressed_event: expected %0b, actual %0b",
                                         want.pressed_event, got.pressed_event));
                end
                if (got.pending_flags !== want.pending_flags) begin
                    note_error($sformatf("pending_flags: expected %b, actual %b",
                                         want.pending_flags, got.pending_flags));
                end
            end
        end
    end

    // Sends one beat; the sender runs in bursts and drops tvalid for a gap after each one.
    task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [PIN_W-1:0] pins,
                             input logic [IDX_W-1:0] idx);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {2'b00, idx, pins};
        i_s_axis_tuser <= mode;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        expected_reports.push_back(predict_debounce(mode, pins, idx));
        burst_left--;
        if (burst_left == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_PRESSED_LEVEL: press_lv = value[0];
            CFG_LONG_DELAY:    long_dly = value;
            default:           rep_int = value;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic level, input logic [TIMER_W-1:0] dly,
                              input logic [TIMER_W-1:0] rep);
        drain_results();
        write_cfg(CFG_PRESSED_LEVEL, {7'd0, level});
        write_cfg(CFG_LONG_DELAY, dly);
        write_cfg(CFG_REPEAT_INTERVAL, rep);
    endtask

    // After reset level 0 means pressed, so an idle pin already counts as held
    // and the zero timer repeats on the first agreeing tick.
    task automatic test_reset_state();
        send_beat(MODE_TICK, 4'h0, 2'd0);
        send_beat(MODE_READ, 4'h0, 2'd0);
        send_beat(MODE_READ, 4'hF, 2'd3);
        send_beat(MODE_UNUSED, 4'hF, 2'd1);
        repeat (3) send_beat(MODE_TICK, 4'hF, 2'd2);
        send_beat(MODE_READ, 4'h0, 2'd1);
        send_beat(MODE_READ, 4'h0, 2'd2);
        send_beat(MODE_READ, 4'h0, 2'd2);
    endtask

    // Zero delays: a new press and every following held tick raise the flag.
    task automatic test_press_repeat();
        set_config(1'b1, 8'd0, 8'd0);
        repeat (3) send_beat(MODE_TICK, 4'h0, 2'd0);
        repeat (3) send_beat(MODE_TICK, 4'h5, 2'd1);
        send_beat(MODE_TICK, 4'h5, 2'd3);
        send_beat(MODE_READ, 4'hA, 2'd0);
        send_beat(MODE_READ, 4'h0, 2'd2);
        send_beat(MODE_TICK, 4'h5, 2'd0);
        send_beat(MODE_READ, 4'h0, 2'd0);
        send_beat(MODE_TOGGLE, 4'h0, 2'd1);
        send_beat(MODE_READ, 4'h0, 2'd1);
        send_beat(MODE_TOGGLE, 4'h0, 2'd0);
    endtask

    // Buttons are held in patterns with occasional bounce; reads, toggles and
    // unused beats are mixed in.
    task automatic test_random_traffic(input logic level, input logic [TIMER_W-1:0] dly,
                                       input logic [TIMER_W-1:0] rep, input int unsigned count);
        logic [PIN_W-1:0] held;
        logic [PIN_W-1:0] pins;
        int unsigned roll;
        set_config(level, dly, rep);
        held = $urandom;
        for (int unsigned n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 68) begin
                if ($urandom_range(0, 29) == 0) begin
                    held = $urandom;
                end
                pins = held;
                if ($urandom_range(0, 9) == 0) begin
                    pins[$urandom_range(0, PIN_W - 1)] ^= 1'b1;
                end
                send_beat(MODE_TICK, pins, IDX_W'($urandom));
            end else if (roll < 88) begin
                send_beat(MODE_READ, PIN_W'($urandom), IDX_W'($urandom));
            end else if (roll < 96) begin
                send_beat(MODE_TOGGLE, PIN_W'($urandom), IDX_W'($urandom));
            end else begin
                send_beat(MODE_UNUSED, PIN_W'($urandom), IDX_W'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= CFG_PRESSED_LEVEL;
        i_cfg_data <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata <= '0;
        i_s_axis_tuser <= MODE_TICK;
        i_m_axis_tready <= 1'b0;
        hist_new = '0;
        hist_mid = '0;
        hist_old = '0;
        stable_lv = '0;
        ev_flag = '0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            hold_cnt[b] = '0;
        end
        press_lv = 1'b0;
        long_dly = LONG_DELAY_RST;
        rep_int = REPEAT_INTERVAL_RST;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_press_repeat();
        test_random_traffic(1'b1, 8'd3, 8'd1, 185);
        test_random_traffic(1'b0, 8'd6, 8'd2, 185);
        test_random_traffic(1'b1, 8'd0, 8'd0, 185);
        test_random_traffic(1'b0, 8'd255, 8'd255, 185);
        test_random_traffic(1'b1, 8'd10, 8'd3, 185);
        test_random_traffic(1'b0, 8'd1, 8'd0, 185);
        drain_results();

        if (error_count == 0) begin
            $display("button_debounce_autorepeat_unit: match");
        end else begin
            $display("button_debounce_autorepeat_unit: mismatch");
        end
        $finish;
    end

endmodule
